[design/cmfs_pkg.sv]
// shared types and constants for the cube map face select pipeline
package cmfs_pkg;

    localparam int DIR_W   = 16;
    localparam int MAG_W   = 16;
    localparam int SGN_W   = DIR_W + 1;
    localparam int COORD_W = 17;
    localparam int FACE_W  = 3;

    // long division: 20 quotient bits, the top three always zero
    localparam int DIV_STEPS   = 20;
    localparam int DIV_STAGES  = 5;
    localparam int STAGE_STEPS = DIV_STEPS / DIV_STAGES;
    localparam int PRE_SHIFT   = DIV_STEPS - COORD_W + 2;
    localparam int FRAC_SHIFT  = 15;
    localparam int NUM_LANES   = 2;
    localparam int LANE_U      = 0;
    localparam int LANE_V      = 1;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // item leaving the axis select stages
    typedef struct packed {
        logic               valid;
        t_face              face;
        logic               zero;
        logic [MAG_W-1:0]   mag;
        logic [COORD_W-1:0] num_u;
        logic [COORD_W-1:0] num_v;
    } t_axis_word;

    typedef struct packed {
        logic [MAG_W-1:0]     rem;
        logic [DIV_STEPS-1:0] dvd;
        logic [DIV_STEPS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic                        valid;
        t_face                       face;
        logic                        zero;
        logic [MAG_W-1:0]            mag;
        t_div_lane [NUM_LANES-1:0]   lane;
    } t_div_word;

endpackage

[design/cmfs_axis.sv]
// input capture, major axis select and numerator forming (three stages)
module cmfs_axis (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cmfs_pkg::DIR_W-1:0]  i_dir_x,
    input  logic [cmfs_pkg::DIR_W-1:0]  i_dir_y,
    input  logic [cmfs_pkg::DIR_W-1:0]  i_dir_z,
    output cmfs_pkg::t_axis_word        o_word
);
    import cmfs_pkg::*;

    function automatic logic [SGN_W-1:0] sext(input logic [DIR_W-1:0] v);
        return {v[DIR_W-1], v};
    endfunction

    function automatic logic [SGN_W-1:0] sneg(input logic [DIR_W-1:0] v);
        return SGN_W'(0) - {v[DIR_W-1], v};
    endfunction

    function automatic logic [MAG_W-1:0] absv(input logic [DIR_W-1:0] v);
        return v[DIR_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    // stage 1: capture
    logic             r_v1;
    logic [DIR_W-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_x <= i_dir_x;
        r_y <= i_dir_y;
        r_z <= i_dir_z;
    end

    // stage 2: magnitudes, major axis, signed pair
    logic [MAG_W-1:0] ax, ay, az;
    logic             zero;
    t_face            n_face;
    logic [MAG_W-1:0] n_mag;
    logic [SGN_W-1:0] n_su, n_sv;

    always_comb begin
        ax   = absv(r_x);
        ay   = absv(r_y);
        az   = absv(r_z);
        zero = (ax == '0) && (ay == '0) && (az == '0);
        priority if (ax >= ay && ax >= az) begin
            n_mag = ax;
            if (!r_x[DIR_W-1]) begin
                n_face = FACE_POS_X; n_su = sneg(r_z); n_sv = sneg(r_y);
            end else begin
                n_face = FACE_NEG_X; n_su = sext(r_z); n_sv = sneg(r_y);
            end
        end else if (ay >= az) begin
            n_mag = ay;
            if (!r_y[DIR_W-1]) begin
                n_face = FACE_POS_Y; n_su = sext(r_x); n_sv = sext(r_z);
            end else begin
                n_face = FACE_NEG_Y; n_su = sext(r_x); n_sv = sneg(r_z);
            end
        end else begin
            n_mag = az;
            if (!r_z[DIR_W-1]) begin
                n_face = FACE_POS_Z; n_su = sext(r_x); n_sv = sneg(r_y);
            end else begin
                n_face = FACE_NEG_Z; n_su = sneg(r_x); n_sv = sneg(r_y);
            end
        end
        // zero vector: divisor 1 and numerator 1 give exactly one half
        if (zero) begin
            n_mag = MAG_W'(1);
        end
    end

    logic             r_v2;
    t_face            r_face;
    logic             r_zero;
    logic [MAG_W-1:0] r_mag;
    logic [SGN_W-1:0] r_su, r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_face <= n_face;
        r_zero <= zero;
        r_mag  <= n_mag;
        r_su   <= n_su;
        r_sv   <= n_sv;
    end

    // stage 3: numerators s + mag, always in 0 .. 2*mag
    logic [SGN_W:0] sum_u, sum_v;
    t_axis_word     n_word;

    always_comb begin
        sum_u        = {r_su[SGN_W-1], r_su} + {2'b00, r_mag};
        sum_v        = {r_sv[SGN_W-1], r_sv} + {2'b00, r_mag};
        n_word.valid = r_v2;
        n_word.face  = r_face;
        n_word.zero  = r_zero;
        n_word.mag   = r_mag;
        n_word.num_u = sum_u[COORD_W-1:0];
        n_word.num_v = sum_v[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_word.valid <= 1'b0;
        end else begin
            o_word.valid <= n_word.valid;
        end
        o_word.face  <= n_word.face;
        o_word.zero  <= n_word.zero;
        o_word.mag   <= n_word.mag;
        o_word.num_u <= n_word.num_u;
        o_word.num_v <= n_word.num_v;
    end

endmodule

[design/cmfs_div.sv]
// pipelined restoring divider for both face coordinates, four steps per stage
module cmfs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmfs_pkg::t_axis_word          i_word,
    output logic                          o_valid,
    output logic [cmfs_pkg::FACE_W-1:0]   o_face,
    output logic [cmfs_pkg::COORD_W-1:0]  o_coord_u,
    output logic [cmfs_pkg::COORD_W-1:0]  o_coord_v,
    output logic                          o_zero
);
    import cmfs_pkg::*;

    function automatic t_div_lane div_step(input t_div_lane l, input logic [MAG_W-1:0] d);
        logic [MAG_W:0] trial;
        t_div_lane      r;
        trial = {l.rem, l.dvd[DIV_STEPS-1]};
        r.dvd = {l.dvd[DIV_STEPS-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            r.rem = MAG_W'(trial - {1'b0, d});
            r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            r.rem = trial[MAG_W-1:0];
            r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    t_div_word w_in;
    t_div_word r_stage [1:DIV_STAGES];

    // dividend is num << 15; high bits start the remainder, low bits shift in
    always_comb begin
        w_in.valid = i_word.valid;
        w_in.face  = i_word.face;
        w_in.zero  = i_word.zero;
        w_in.mag   = i_word.mag;
        w_in.lane[LANE_U].rem = MAG_W'(i_word.num_u[COORD_W-1:PRE_SHIFT]);
        w_in.lane[LANE_U].dvd = {i_word.num_u[PRE_SHIFT-1:0], FRAC_SHIFT'(0)};
        w_in.lane[LANE_U].quo = '0;
        w_in.lane[LANE_V].rem = MAG_W'(i_word.num_v[COORD_W-1:PRE_SHIFT]);
        w_in.lane[LANE_V].dvd = {i_word.num_v[PRE_SHIFT-1:0], FRAC_SHIFT'(0)};
        w_in.lane[LANE_V].quo = '0;
    end

    for (genvar st = 1; st <= DIV_STAGES; st++) begin : g_stage
        t_div_word stage_in;
        t_div_word n_word;

        if (st == 1) begin : g_first
            assign stage_in = w_in;
        end else begin : g_next
            assign stage_in = r_stage[st-1];
        end

        always_comb begin
            n_word = stage_in;
            for (int k = 0; k < STAGE_STEPS; k++) begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    n_word.lane[l] = div_step(n_word.lane[l], n_word.mag);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[st].valid <= 1'b0;
            end else begin
                r_stage[st].valid <= n_word.valid;
            end
            r_stage[st].face <= n_word.face;
            r_stage[st].zero <= n_word.zero;
            r_stage[st].mag  <= n_word.mag;
            r_stage[st].lane <= n_word.lane;
        end
    end

    assign o_valid   = r_stage[DIV_STAGES].valid;
    assign o_face    = r_stage[DIV_STAGES].face;
    assign o_zero    = r_stage[DIV_STAGES].zero;
    assign o_coord_u = r_stage[DIV_STAGES].lane[LANE_U].quo[COORD_W-1:0];
    assign o_coord_v = r_stage[DIV_STAGES].lane[LANE_V].quo[COORD_W-1:0];

endmodule

[design/cube_map_face_select.sv]
// top level of the cube map face select pipeline
//
//  channel   ports                                     marker
//  command   i_dir_x i_dir_y i_dir_z                   start (taken when busy low)
//  result    o_face o_coord_u o_coord_v o_zero_vector  o_valid, one cycle each
//
// a new direction is taken every cycle; busy stays low
// each result passes through 3 axis/numerator stages,
// then 5 divider stages of 4 quotient bits each (20-step long division)
// synchronous active-low reset clears the valid bits of every stage
// results leave in command order and cannot be held off
module cube_map_face_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cmfs_pkg::DIR_W-1:0]    i_dir_x,
    input  logic [cmfs_pkg::DIR_W-1:0]    i_dir_y,
    input  logic [cmfs_pkg::DIR_W-1:0]    i_dir_z,
    output logic                          o_valid,
    output logic [cmfs_pkg::FACE_W-1:0]   o_face,
    output logic [cmfs_pkg::COORD_W-1:0]  o_coord_u,
    output logic [cmfs_pkg::COORD_W-1:0]  o_coord_v,
    output logic                          o_zero_vector
);
    import cmfs_pkg::*;

    t_axis_word axis_word;

    assign busy = 1'b0;

    cmfs_axis u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_word  (axis_word)
    );

    cmfs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (axis_word),
        .o_valid   (o_valid),
        .o_face    (o_face),
        .o_coord_u (o_coord_u),
        .o_coord_v (o_coord_v),
        .o_zero    (o_zero_vector)
    );

endmodule
